[rtl/core/lfu_cache_lru_tiebreak_assert.svh]
// Assertion macros used by the checker file of the LFU cache.
// Each macro names one property and reports a failure with $error.
`ifndef LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
// An implication that must hold on every clock edge out of reset.
`define LFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// An implication whose consequent must hold in the cycle after its antecedent.
`define LFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/core/lfc_pkg.sv]
// Package of the LFU cache: sizes, types and the sequencer state type.
// Used by the top level, the slot memory and the sweep unit; depends on nothing.
package lfc_pkg;
  localparam int Entries   = 16;
  localparam int CountBits = 16;
  localparam int IdxW      = $clog2(Entries);
  localparam int OccW      = $clog2(Entries + 1);
  localparam int CapW      = 5;
  localparam int KeyW      = 32;
  localparam int ValW      = 32;
  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } seq_state_t;

  // One slot as it lies in the slot memory.
  typedef struct packed {
    logic [KeyW-1:0]      key;
    logic [ValW-1:0]      value;
    logic [CountBits-1:0] count;
  } slot_word_t;

  // Results of the search over all slots.
  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] hit_idx;
    logic            free_ok;
    logic [IdxW-1:0] free_idx;
    logic [IdxW-1:0] vic_idx;
  } scan_res_t;
endpackage

[rtl/core/lfu_cache_lru_tiebreak.sv]
// Channel | Direction | Handshake        | Words
// in_     | into      | valid / stall    | mode, lookup_key, write_value
// out_    | out of    | valid / stall    | hit, read_value
// cfg_    | into      | valid / ready    | active_capacity
// A result is offered after its word has been through a sweep of the slot memory, one
// slot a cycle through its single read port, then a re-read of the hit slot and a
// write-back; the block takes no new word until that result has gone.
// Reset is synchronous and clears the valid bits, ranks and occupancy.
// A stalled result holds; the next word is taken once the result has gone.
// Top level of the LFU cache; uses lfc_pkg, lfc_slot_ram and lfc_scan.
module lfu_cache_lru_tiebreak (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_lookup_key,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [31:0] out_read_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_active_capacity
);
  localparam int IdxW = lfc_pkg::IdxW;
  localparam int OccW = lfc_pkg::OccW;
  localparam int N    = lfc_pkg::Entries;

  lfc_pkg::seq_state_t         st_r, st_nxt;
  logic [lfc_pkg::CapW-1:0]    cap_r;
  logic [N-1:0]                valid_r;
  logic [IdxW-1:0]             rank_r [N];
  logic [OccW-1:0]             occ_r;
  logic                        mode_r;
  logic [31:0]                 key_r, val_r;
  logic                        hit_r;
  logic [31:0]                 rdv_r;

  logic                        scan_start, scan_done;
  lfc_pkg::scan_res_t          sres;
  logic [IdxW-1:0]             scan_rd_idx, rd_idx;
  lfc_pkg::slot_word_t         rd_data, wr_data;
  logic                        wr_en;
  logic [IdxW-1:0]             wr_idx;

  logic [OccW-1:0]             cap_eff;
  logic                        full;
  logic                        do_evict;
  logic [N-1:0]                valid_mid;
  logic [IdxW-1:0]             tgt_idx;
  logic                        ins_ok;
  logic [lfc_pkg::CountBits-1:0] cnt_inc;

  assign cap_eff = (cap_r > lfc_pkg::CapW'(N)) ? OccW'(N) : OccW'(cap_r);
  assign full    = (occ_r >= cap_eff);
  assign do_evict = !sres.found && full && (occ_r != '0);
  assign ins_ok  = do_evict || sres.free_ok;
  assign tgt_idx = sres.found ? sres.hit_idx : (do_evict ? sres.vic_idx : sres.free_idx);

  assign in_stall  = (st_r != lfc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign scan_start = (st_r == lfc_pkg::ST_IDLE) && in_valid;

  lfc_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .key     (key_r),
    .valid   (valid_r),
    .rank    (rank_r),
    .rd_idx  (scan_rd_idx),
    .rd_data (rd_data),
    .done    (scan_done),
    .res     (sres)
  );

  // The memory port reads for the sweep, then the hit slot.
  assign rd_idx = (st_r == lfc_pkg::ST_SCAN) ? scan_rd_idx : sres.hit_idx;

  lfc_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  // Saturating count increase of the hit slot.
  assign cnt_inc = (rd_data.count == lfc_pkg::CountMax) ? rd_data.count
                                                       : rd_data.count + 1'b1;

  // Write-back in the write state.
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = tgt_idx;
    wr_data = rd_data;
    if (st_r == lfc_pkg::ST_WRITE) begin
      if (sres.found) begin
        wr_en = !(mode_r && cap_r == '0) || !mode_r;
        wr_data.count = cnt_inc;
        if (mode_r) begin
          wr_data.value = val_r;
        end
      end else if (mode_r && cap_r != '0 && ins_ok) begin
        wr_en         = 1'b1;
        wr_data.key   = key_r;
        wr_data.value = val_r;
        wr_data.count = lfc_pkg::CountBits'(1);
      end
    end
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      lfc_pkg::ST_IDLE:  if (in_valid) st_nxt = lfc_pkg::ST_SCAN;
      lfc_pkg::ST_SCAN:  if (scan_done) st_nxt = lfc_pkg::ST_READ;
      lfc_pkg::ST_READ:  st_nxt = lfc_pkg::ST_WRITE;
      lfc_pkg::ST_WRITE: st_nxt = lfc_pkg::ST_OUT;
      lfc_pkg::ST_OUT:   if (!out_stall) st_nxt = lfc_pkg::ST_IDLE;
      default:           st_nxt = lfc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    out_valid      = (st_r == lfc_pkg::ST_OUT);
    out_hit        = hit_r;
    out_read_value = rdv_r;
  end

  assign valid_mid = do_evict ? (valid_r & ~(N'(1) << sres.vic_idx)) : valid_r;

  // Control state, ranks and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= lfc_pkg::ST_IDLE;
      cap_r   <= lfc_pkg::CapReset;
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_active_capacity;
      end
      if (st_r == lfc_pkg::ST_WRITE) begin
        if (sres.found && !(mode_r && cap_r == '0)) begin
          // Touch: younger entries age by one.
          for (int i = 0; i < N; i++) begin
            if (valid_r[i] && rank_r[i] < rank_r[sres.hit_idx]) begin
              rank_r[i] <= rank_r[i] + 1'b1;
            end
          end
          rank_r[sres.hit_idx] <= '0;
        end else if (!sres.found && mode_r && cap_r != '0 && ins_ok) begin
          // Insert: any victim leaves, survivors younger than it (all if none) age, newcomer is youngest.
          for (int i = 0; i < N; i++) begin
            if (valid_mid[i] &&
                !(do_evict && rank_r[i] > rank_r[sres.vic_idx])) begin
              rank_r[i] <= rank_r[i] + 1'b1;
            end
          end
          rank_r[tgt_idx] <= '0;
          valid_r         <= valid_mid | (N'(1) << tgt_idx);
          if (!do_evict) begin
            occ_r <= occ_r + 1'b1;
          end
        end
      end
    end
  end

  // Request and result words.
  always_ff @(posedge clk) begin
    if (scan_start) begin
      mode_r <= in_mode;
      key_r  <= in_lookup_key;
      val_r  <= in_write_value;
    end
    if (st_r == lfc_pkg::ST_WRITE) begin
      hit_r <= sres.found && !(mode_r && cap_r == '0);
      rdv_r <= (sres.found && !mode_r) ? rd_data.value : '0;
    end
  end
endmodule

[rtl/core/lfc_slot_ram.sv]
// Slot memory of the LFU cache: key, value and use count of each slot.
// One write port and one registered read port; uses lfc_pkg.
module lfc_slot_ram (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [lfc_pkg::IdxW-1:0]        wr_idx,
  input  lfc_pkg::slot_word_t             wr_data,
  input  logic [lfc_pkg::IdxW-1:0]        rd_idx,
  output lfc_pkg::slot_word_t             rd_data
);
  lfc_pkg::slot_word_t mem [lfc_pkg::Entries];
  lfc_pkg::slot_word_t rd_data_r;

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[rd_idx];
  end

  assign rd_data = rd_data_r;
endmodule

[rtl/core/lfc_scan.sv]
// Sweep unit of the LFU cache: walks all slots one per cycle, reading the
// slot memory, to find the key match, a free slot and the eviction victim.
// Uses lfc_pkg.
module lfc_scan (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [lfc_pkg::KeyW-1:0]         key,
  input  logic [lfc_pkg::Entries-1:0]      valid,
  input  logic [lfc_pkg::IdxW-1:0]         rank [lfc_pkg::Entries],
  output logic [lfc_pkg::IdxW-1:0]         rd_idx,
  input  lfc_pkg::slot_word_t              rd_data,
  output logic                             done,
  output lfc_pkg::scan_res_t               res
);
  localparam int CntW = lfc_pkg::IdxW + 1;

  logic                         busy_r, busy_nxt;
  logic [CntW-1:0]              ptr_r, ptr_nxt;
  logic                         chk_r, chk_nxt;
  logic [lfc_pkg::IdxW-1:0]     chk_idx_r;
  lfc_pkg::scan_res_t           res_r, res_nxt;
  logic                         have_vic_r, have_vic_nxt;
  logic [lfc_pkg::CountBits-1:0] vic_cnt_r, vic_cnt_nxt;
  logic                         done_r, done_nxt;
  logic                         better;

  assign rd_idx = ptr_r[lfc_pkg::IdxW-1:0];

  // The slot read last cycle beats the current victim on lower count, or
  // equal count and older touch.
  assign better = !have_vic_r || (rd_data.count < vic_cnt_r) ||
                  ((rd_data.count == vic_cnt_r) &&
                   (rank[chk_idx_r] > rank[res_r.vic_idx]));

  // Sweep control and running search.
  always_comb begin
    busy_nxt     = busy_r;
    ptr_nxt      = ptr_r;
    chk_nxt      = 1'b0;
    res_nxt      = res_r;
    have_vic_nxt = have_vic_r;
    vic_cnt_nxt  = vic_cnt_r;
    done_nxt     = 1'b0;
    if (start) begin
      busy_nxt     = 1'b1;
      ptr_nxt      = '0;
      res_nxt      = '0;
      have_vic_nxt = 1'b0;
    end else begin
      if (busy_r) begin
        chk_nxt = 1'b1;
        if (ptr_r == CntW'(lfc_pkg::Entries - 1)) begin
          busy_nxt = 1'b0;
        end
        ptr_nxt = ptr_r + CntW'(1);
      end
      if (chk_r) begin
        if (valid[chk_idx_r]) begin
          if (!res_r.found && rd_data.key == key) begin
            res_nxt.found   = 1'b1;
            res_nxt.hit_idx = chk_idx_r;
          end
          if (better) begin
            have_vic_nxt    = 1'b1;
            vic_cnt_nxt     = rd_data.count;
            res_nxt.vic_idx = chk_idx_r;
          end
        end else if (!res_r.free_ok) begin
          res_nxt.free_ok  = 1'b1;
          res_nxt.free_idx = chk_idx_r;
        end
        if (!busy_r) begin
          done_nxt = 1'b1;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      chk_r  <= chk_nxt;
      done_r <= done_nxt;
    end
  end

  // Search registers.
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    chk_idx_r  <= ptr_r[lfc_pkg::IdxW-1:0];
    res_r      <= res_nxt;
    have_vic_r <= have_vic_nxt;
    vic_cnt_r  <= vic_cnt_nxt;
  end

  assign done = done_r;
  assign res  = res_r;
endmodule

[rtl/core/lfc_checker.sv]
// Port checker of the LFU cache, bound to the top level.
// Uses the assertion macros of lfu_cache_lru_tiebreak_assert.svh.
`include "lfu_cache_lru_tiebreak_assert.svh"
module lfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [31:0] out_read_value
);
  // A result word that is stalled stays offered.
  `LFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
  // A stalled result keeps its value.
  `LFC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_read_value) && $stable(out_hit), "result changed")
  // A word is taken only while no result is pending.
  `LFC_ASSERT_IMP(a_one_at_a_time, clk, rst_n, out_valid, in_stall, "input taken with result pending")
  // An accepted word never yields its result in the next cycle.
  `LFC_ASSERT_NEXT(a_no_instant, clk, rst_n, in_valid && !in_stall, !out_valid, "result too early")
endmodule

bind lfu_cache_lru_tiebreak lfc_checker u_lfc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hit        (out_hit),
  .out_read_value (out_read_value)
);
